@@ hw/rtl/lepc_pkg.sv @@
// Shared types and constants for the lidar echo point converter.
// Depends on nothing; every other file but lepc_fifo refers to it by scoped names.
`default_nettype none

package lepc_pkg;

    localparam int ROW_W   = 11;   // sub_frame*6 + 5 stays below 2048
    localparam int COL_W   = 9;    // start_col + 5 stays below 512
    localparam int LINE_W  = 20;   // row*GRID_COLS + col
    localparam int CELL_W  = 18;
    localparam int COORD_W = 16;
    localparam int OFF_W   = 17;
    localparam int POINT_W = 18;
    localparam int TALLY_W = 11;
    localparam int ID_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [TALLY_W-1:0] TALLY_MAX       = 11'd2047;
    localparam logic [TALLY_W-1:0] LIMIT_RESET     = 11'd1664;
    localparam logic [2:0]         ECHO_NUM_RESET  = 3'd5;
    localparam logic [7:0]         SINGLE_COL_MARK = 8'd255;
    localparam logic [2:0]         COLS_WIDE       = 3'd5;
    localparam logic [2:0]         COLS_SINGLE     = 3'd1;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_FORCED   = 2'd2
    } frame_event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ENABLE      = 3'd0,
        REG_ECHO_CHOOSE_ENABLE = 3'd1,
        REG_ECHO_NUMBER        = 3'd2,
        REG_OFFSET_X           = 3'd3,
        REG_OFFSET_Y           = 3'd4,
        REG_OFFSET_Z           = 3'd5,
        REG_FRAME_PACKET_LIMIT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                      filter_enable;
        logic                      echo_choose_enable;
        logic [2:0]                echo_number;
        logic signed [OFF_W-1:0]   offset_x;
        logic signed [OFF_W-1:0]   offset_y;
        logic signed [OFF_W-1:0]   offset_z;
        logic [TALLY_W-1:0]        frame_packet_limit;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]           frame_tag;
        logic [7:0]                sub_frame;
        logic [7:0]                start_col;
        logic [4:0]                slot;
        logic [2:0]                echo;
        logic signed [COORD_W-1:0] raw_x;
        logic signed [COORD_W-1:0] raw_y;
        logic signed [COORD_W-1:0] raw_z;
        logic [7:0]                reflectivity;
        logic                      echo_label;
        logic                      packet_first;
    } in_item_t;

    // Classified sample handed from the front to the back.
    typedef struct packed {
        logic [LINE_W-1:0]         line;
        logic [2:0]                echo;
        logic                      in_range;
        logic                      valid;
        logic signed [COORD_W-1:0] raw_x;
        logic signed [COORD_W-1:0] raw_y;
        logic signed [COORD_W-1:0] raw_z;
        logic [7:0]                reflectivity;
        frame_event_t              frame_event;
        logic [ID_W-1:0]           event_frame_id;
    } front_rec_t;

    typedef struct packed {
        logic [CELL_W-1:0]         cell_index;
        logic                      in_range;
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic signed [POINT_W-1:0] point_z;
        logic [7:0]                intensity;
        logic                      kept;
        frame_event_t              frame_event;
        logic [ID_W-1:0]           event_frame_id;
    } result_t;

    // Column of a payload slot: slot / 6, done with compares.
    function automatic logic [2:0] slot_column(input logic [4:0] slot);
        logic [2:0] c;
        begin
            if (slot >= 5'd30)      c = 3'd5;
            else if (slot >= 5'd24) c = 3'd4;
            else if (slot >= 5'd18) c = 3'd3;
            else if (slot >= 5'd12) c = 3'd2;
            else if (slot >= 5'd6)  c = 3'd1;
            else                    c = 3'd0;
            return c;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lepc_fifo.sv @@
// Small register-based queue used between the stages and at the output.
// Depends on nothing.
`default_nettype none

module lepc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lepc_front.sv @@
// Front stage: frame bookkeeping, grid cell location, range check and echo filter.
// Depends on lepc_pkg.
`default_nettype none

module lepc_front #(
    parameter int GRID_ROWS = 192,
    parameter int GRID_COLS = 256,
    parameter int ECHOES    = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire lepc_pkg::in_item_t item,
    input  wire lepc_pkg::cfg_t     cfg,
    output lepc_pkg::front_rec_t    rec
);

    localparam logic [lepc_pkg::ROW_W-1:0]  ROWS_LIM = lepc_pkg::ROW_W'(GRID_ROWS);
    localparam logic [lepc_pkg::COL_W-1:0]  COLS_LIM = lepc_pkg::COL_W'(GRID_COLS);
    localparam logic [lepc_pkg::LINE_W-1:0] COLS_MUL = lepc_pkg::LINE_W'(GRID_COLS);
    localparam logic [3:0]                  ECHO_LIM = 4'(ECHOES);

    logic                            frame_active_reg, frame_active_next;
    logic [lepc_pkg::ID_W-1:0]       active_id_reg, active_id_next;
    logic [lepc_pkg::TALLY_W-1:0]    tally_reg, tally_next;
    lepc_pkg::frame_event_t          ev;
    logic [lepc_pkg::ID_W-1:0]       ev_id;

    logic [2:0]                      slot_col;
    logic [2:0]                      col_count;
    logic [lepc_pkg::ROW_W-1:0]      row;
    logic [lepc_pkg::COL_W-1:0]      col;
    logic                            in_range;
    logic                            valid;

    // Packet bookkeeping, evaluated only on the first sample of a packet.
    always_comb
    begin
        logic forced;
        logic act;
        forced            = 1'b0;
        act               = frame_active_reg;
        active_id_next    = active_id_reg;
        tally_next        = tally_reg;
        ev                = lepc_pkg::EV_NONE;
        ev_id             = '0;
        if (item.packet_first)
        begin
            if (act && item.frame_tag != active_id_reg)
            begin
                if (tally_reg != '0)
                begin
                    forced = 1'b1;
                    ev     = lepc_pkg::EV_FORCED;
                    ev_id  = active_id_reg;
                end
                act = 1'b0;
            end
            if (!act)
            begin
                active_id_next = item.frame_tag;
                act            = 1'b1;
                tally_next     = '0;
            end
            if (tally_next != lepc_pkg::TALLY_MAX)
            begin
                tally_next = tally_next + 1'b1;
            end
            if (!forced && tally_next >= cfg.frame_packet_limit)
            begin
                ev    = lepc_pkg::EV_COMPLETE;
                ev_id = item.frame_tag;
                act   = 1'b0;
            end
        end
        frame_active_next = act;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_active_reg <= 1'b0;
            active_id_reg    <= '0;
            tally_reg        <= '0;
        end
        else if (accept)
        begin
            frame_active_reg <= frame_active_next;
            active_id_reg    <= active_id_next;
            tally_reg        <= tally_next;
        end
    end

    // Grid location: row = sub_frame*6 + slot mod 6, column = start_col + slot/6.
    always_comb
    begin
        slot_col  = lepc_pkg::slot_column(item.slot);
        col_count = (item.start_col == lepc_pkg::SINGLE_COL_MARK) ?
                    lepc_pkg::COLS_SINGLE : lepc_pkg::COLS_WIDE;
        row = lepc_pkg::ROW_W'({item.sub_frame, 2'b00}) + lepc_pkg::ROW_W'({item.sub_frame, 1'b0})
            + lepc_pkg::ROW_W'(item.slot - 5'({slot_col, 2'b00}) - 5'({slot_col, 1'b0}));
        col = lepc_pkg::COL_W'(item.start_col) + lepc_pkg::COL_W'(slot_col);
        in_range = (slot_col < col_count) && (row < ROWS_LIM) && (col < COLS_LIM)
                   && ({1'b0, item.echo} < ECHO_LIM);
    end

    always_comb
    begin
        valid = 1'b1;
        if (cfg.filter_enable)
        begin
            if (cfg.echo_choose_enable)
            begin
                valid = item.echo_label;
            end
            else if (cfg.echo_number >= 3'd1 && cfg.echo_number <= 3'd3)
            begin
                valid = (item.echo == cfg.echo_number - 3'd1);
            end
            else if (cfg.echo_number == 3'd4)
            begin
                valid = (item.echo <= 3'd2);
            end
        end
    end

    always_comb
    begin
        rec.line           = lepc_pkg::LINE_W'(row) * COLS_MUL + lepc_pkg::LINE_W'(col);
        rec.echo           = item.echo;
        rec.in_range       = in_range;
        rec.valid          = valid;
        rec.raw_x          = item.raw_x;
        rec.raw_y          = item.raw_y;
        rec.raw_z          = item.raw_z;
        rec.reflectivity   = item.reflectivity;
        rec.frame_event    = ev;
        rec.event_frame_id = ev_id;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lepc_back.sv @@
// Back stage: cell index, offset addition and the kept decision.
// Depends on lepc_pkg.
`default_nettype none

module lepc_back #(
    parameter int ECHOES = 3
) (
    input  wire lepc_pkg::front_rec_t rec,
    input  wire lepc_pkg::cfg_t       cfg,
    output lepc_pkg::result_t         res
);

    localparam int PROD_W = lepc_pkg::LINE_W + 4;
    localparam logic [PROD_W-1:0] ECHO_MUL = PROD_W'(ECHOES);

    logic [PROD_W-1:0]                      cell_full;
    logic signed [lepc_pkg::POINT_W-1:0]    sum_x, sum_y, sum_z;
    logic                                   take;

    always_comb
    begin
        cell_full = PROD_W'(rec.line) * ECHO_MUL + PROD_W'(rec.echo);
        sum_x = lepc_pkg::POINT_W'(rec.raw_x) + lepc_pkg::POINT_W'(cfg.offset_x);
        sum_y = lepc_pkg::POINT_W'(rec.raw_y) + lepc_pkg::POINT_W'(cfg.offset_y);
        sum_z = lepc_pkg::POINT_W'(rec.raw_z) + lepc_pkg::POINT_W'(cfg.offset_z);
        take  = rec.in_range && rec.valid;

        res.cell_index     = rec.in_range ? cell_full[lepc_pkg::CELL_W-1:0] : '0;
        res.in_range       = rec.in_range;
        res.point_x        = take ? sum_x : '0;
        res.point_y        = take ? sum_y : '0;
        res.point_z        = take ? sum_z : '0;
        res.intensity      = take ? rec.reflectivity : '0;
        res.kept           = take && (sum_x != '0 || sum_y != '0 || sum_z != '0);
        res.frame_event    = rec.frame_event;
        res.event_frame_id = rec.event_frame_id;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lidar_echo_point_converter.sv @@
// Top level of the lidar echo point converter: configuration registers, front and
// back stages, and the queues between them. Depends on lepc_pkg, lepc_fifo,
// lepc_front and lepc_back.
//
// The block takes one lidar echo sample per beat and gives exactly one result beat
// for it, in order. A sample is taken in any cycle in which full is low, so while
// the consumer keeps up the sustained rate is one sample per clock. The edge that
// takes a sample writes it into the queue between the front and back stages; the
// finished result moves from there into the output queue whenever that queue has
// room, and waits there until the consumer pops it. The front stage does the
// per-packet frame bookkeeping (packet count, completed frame, forced end on a
// frame id change) on the first sample of each packet, locates the grid cell and
// applies the echo filter; the back stage builds the cell index and adds the
// offsets in 1/512 units. Both queues are two entries deep, so either side may
// stall without losing or repeating a beat. Configuration is written through
// cfg_valid/cfg_ready, which is always ready; writes are meant to happen while the
// block is idle, and an index beyond the register list is ignored.
`default_nettype none

module lidar_echo_point_converter #(
    parameter int GRID_ROWS = 192,
    parameter int GRID_COLS = 256,
    parameter int ECHOES    = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        push,
    output logic             full,
    input  wire logic        func,
    input  wire logic [31:0] frame_tag,
    input  wire logic [7:0]  sub_frame,
    input  wire logic [7:0]  start_col,
    input  wire logic [4:0]  slot,
    input  wire logic [2:0]  echo,
    input  wire logic signed [15:0] raw_x,
    input  wire logic signed [15:0] raw_y,
    input  wire logic signed [15:0] raw_z,
    input  wire logic [7:0]  reflectivity,
    input  wire logic        echo_label,
    input  wire logic        packet_first,

    output logic             empty,
    input  wire logic        pop,
    output logic [17:0]      cell_index,
    output logic             in_range,
    output logic signed [17:0] point_x,
    output logic signed [17:0] point_y,
    output logic signed [17:0] point_z,
    output logic [7:0]       intensity,
    output logic             kept,
    output logic [1:0]       frame_event,
    output logic [31:0]      event_frame_id,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    localparam int REC_W = $bits(lepc_pkg::front_rec_t);
    localparam int RES_W = $bits(lepc_pkg::result_t);
    localparam int QUEUE_DEPTH = 2;

    lepc_pkg::cfg_t       cfg_reg;
    lepc_pkg::in_item_t   item;
    lepc_pkg::front_rec_t front_rec;
    lepc_pkg::front_rec_t mid_rec;
    lepc_pkg::result_t    back_res;
    lepc_pkg::result_t    out_res;
    logic                 accept;
    logic                 mid_empty;
    logic                 out_full;
    logic                 move;
    logic [REC_W-1:0]     mid_bits;
    logic [RES_W-1:0]     out_bits;

    // The item kind is always a single echo sample, so func carries no information.
    logic unused_func;
    assign unused_func = func;

    assign cfg_ready = 1'b1;

    // Configuration registers. They are read directly by both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_enable      <= 1'b0;
            cfg_reg.echo_choose_enable <= 1'b1;
            cfg_reg.echo_number        <= lepc_pkg::ECHO_NUM_RESET;
            cfg_reg.offset_x           <= '0;
            cfg_reg.offset_y           <= '0;
            cfg_reg.offset_z           <= '0;
            cfg_reg.frame_packet_limit <= lepc_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lepc_pkg::REG_FILTER_ENABLE:      cfg_reg.filter_enable      <= cfg_data[0];
                lepc_pkg::REG_ECHO_CHOOSE_ENABLE: cfg_reg.echo_choose_enable <= cfg_data[0];
                lepc_pkg::REG_ECHO_NUMBER:        cfg_reg.echo_number        <= cfg_data[2:0];
                lepc_pkg::REG_OFFSET_X:           cfg_reg.offset_x           <= cfg_data;
                lepc_pkg::REG_OFFSET_Y:           cfg_reg.offset_y           <= cfg_data;
                lepc_pkg::REG_OFFSET_Z:           cfg_reg.offset_z           <= cfg_data;
                lepc_pkg::REG_FRAME_PACKET_LIMIT:
                    cfg_reg.frame_packet_limit <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        item.frame_tag    = frame_tag;
        item.sub_frame    = sub_frame;
        item.start_col    = start_col;
        item.slot         = slot;
        item.echo         = echo;
        item.raw_x        = raw_x;
        item.raw_y        = raw_y;
        item.raw_z        = raw_z;
        item.reflectivity = reflectivity;
        item.echo_label   = echo_label;
        item.packet_first = packet_first;
    end

    assign accept = push && !full;

    lepc_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .ECHOES    (ECHOES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .rec    (front_rec)
    );

    // Queue between the front and back stages; its full flag is the input back-pressure.
    lepc_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_rec),
        .full      (full),
        .pop       (move),
        .empty     (mid_empty),
        .head_data (mid_bits)
    );

    assign mid_rec = mid_bits;
    assign move    = !mid_empty && !out_full;

    lepc_back #(
        .ECHOES (ECHOES)
    ) u_back (
        .rec (mid_rec),
        .cfg (cfg_reg),
        .res (back_res)
    );

    // Output queue: holds finished results while the consumer stalls.
    lepc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (move),
        .push_data (back_res),
        .full      (out_full),
        .pop       (pop),
        .empty     (empty),
        .head_data (out_bits)
    );

    assign out_res        = out_bits;
    assign cell_index     = out_res.cell_index;
    assign in_range       = out_res.in_range;
    assign point_x        = out_res.point_x;
    assign point_y        = out_res.point_y;
    assign point_z        = out_res.point_z;
    assign intensity      = out_res.intensity;
    assign kept           = out_res.kept;
    assign frame_event    = out_res.frame_event;
    assign event_frame_id = out_res.event_frame_id;

endmodule

`default_nettype wire

@@ hw/rtl/lepc_checker.sv @@
// Port-level checker for the lidar echo point converter, bound to the top level.
// Depends on lepc_pkg for the frame event codes.
`default_nettype none

module lepc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [17:0] cell_index,
    input wire logic        in_range,
    input wire logic [17:0] point_x,
    input wire logic [17:0] point_y,
    input wire logic [17:0] point_z,
    input wire logic [7:0]  intensity,
    input wire logic        kept,
    input wire logic [1:0]  frame_event,
    input wire logic [31:0] event_frame_id
);

    // A kept point is always inside the grid and not at the origin.
    a_kept_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kept) |-> (in_range && (point_x != '0 || point_y != '0 || point_z != '0)))
        else $error("kept point out of range or at origin");

    // A sample outside the grid carries no cell and no point.
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !in_range) |-> (cell_index == '0 && point_x == '0 && point_y == '0
                                   && point_z == '0 && intensity == '0))
        else $error("out-of-range sample carries data");

    // Without an event the event frame id is zero, and the code is a defined one.
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((frame_event == lepc_pkg::EV_NONE && event_frame_id == '0)
                    || frame_event == lepc_pkg::EV_COMPLETE
                    || frame_event == lepc_pkg::EV_FORCED))
        else $error("bad frame event");

    // A waiting result is not withdrawn before it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cell_index) && $stable(event_frame_id)))
        else $error("waiting result changed");

endmodule

bind lidar_echo_point_converter lepc_checker u_lepc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .cell_index     (cell_index),
    .in_range       (in_range),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .intensity      (intensity),
    .kept           (kept),
    .frame_event    (frame_event),
    .event_frame_id (event_frame_id)
);

`default_nettype wire
